>>> rtl/assert_macros.svh
// Assertion macros shared by the RTL files.
// Active in simulation; empty when SYNTH is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define ASSERT_IMPLIES(label, clk, rst, a, c) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) else $error("label");
`define ASSERT_NEXT(label, clk, rst, a, c) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) else $error("label");
`else
`define ASSERT_IMPLIES(label, clk, rst, a, c)
`define ASSERT_NEXT(label, clk, rst, a, c)
`endif
`endif

>>> rtl/rdec_pkg.sv
// Package for the decode/execute core: payload types, codes and defaults.
// No dependencies.
`timescale 1ns / 1ps
package rdec_pkg;
  localparam int unsigned MemWordsDefault = 4096;

  typedef struct packed {
    logic [31:0] instruction;
    logic [11:0] inst_address;
  } in_item_t;

  typedef struct packed {
    logic        write_enable;
    logic [4:0]  write_reg;
    logic [31:0] write_value;
    logic        redirect;
    logic [11:0] target;
    logic        fault;
  } out_item_t;

  localparam logic [1:0] FmtRrr = 2'd0;
  localparam logic [1:0] FmtRri = 2'd1;
  localparam logic [1:0] FmtBrc = 2'd2;
  localparam logic [1:0] FmtCall = 2'd3;

  localparam logic [3:0] OpJmpl = 4'd0;
  localparam logic [3:0] OpArith = 4'd1;
  localparam logic [3:0] OpLogic = 4'd2;
  localparam logic [3:0] OpSet = 4'd3;
  localparam logic [3:0] OpMem = 4'd5;
  localparam logic [3:0] OpRet = 4'd15;
  localparam logic [3:0] OpJmp = 4'd15;
  localparam logic [3:0] OpLui = 4'd13;

  localparam logic [4:0] FnLdw = 5'd0;
  localparam logic [4:0] FnStw = 5'd4;

  // Compare conditions shared by SET functions and branch opcodes (0..9).
  function automatic logic cmp_cond(input logic [3:0] c, input logic [31:0] a,
                                    input logic [31:0] b);
    logic slt, sgt, ult, ugt, eq;
    slt = $signed(a) < $signed(b);
    sgt = $signed(a) > $signed(b);
    ult = a < b;
    ugt = a > b;
    eq  = a == b;
    unique case (c)
      4'd0: cmp_cond = eq;
      4'd1: cmp_cond = !eq;
      4'd2: cmp_cond = slt;
      4'd3: cmp_cond = ult;
      4'd4: cmp_cond = !sgt;
      4'd5: cmp_cond = !ugt;
      4'd6: cmp_cond = sgt;
      4'd7: cmp_cond = ugt;
      4'd8: cmp_cond = !slt;
      4'd9: cmp_cond = !ult;
      default: cmp_cond = 1'b0;
    endcase
  endfunction
endpackage

>>> rtl/rdec_alu.sv
// Combinational ALU for the decode/execute core (register and immediate ops).
// Depends on rdec_pkg.
`timescale 1ns / 1ps
module rdec_alu (
  input  logic [31:0] ins,
  input  logic [31:0] ra,
  input  logic [31:0] rb,
  input  logic [31:0] prod,
  output logic        valid_op,
  output logic [31:0] result
);
  import rdec_pkg::*;
  logic [1:0]  fmt;
  logic [3:0]  op;
  logic [4:0]  fn;
  logic [31:0] uimm, simm, b;
  logic [4:0]  sh;

  assign fmt  = ins[31:30];
  assign op   = ins[29:26];
  assign fn   = ins[10:6];
  assign uimm = {16'd0, ins[15:0]};
  assign simm = {{16{ins[15]}}, ins[15:0]};
  assign b    = (fmt == FmtRrr) ? rb : uimm;
  assign sh   = b[4:0];

  // Result select over both formats
  always_comb begin
    valid_op = 1'b1;
    result   = '0;
    if (fmt == FmtRrr && op == OpArith) begin
      unique case (fn)
        5'd0, 5'd1: result = ra + rb;
        5'd2, 5'd3: result = ra - rb;
        5'd4, 5'd5: result = prod;
        default: valid_op = 1'b0;
      endcase
    end else if (fmt == FmtRrr && op == OpLogic) begin
      unique case (fn)
        5'd0: result = ra & rb;
        5'd1: result = ra | rb;
        5'd2: result = ra ^ rb;
        5'd3: result = ~(ra & rb);
        5'd4: result = ~(ra | rb);
        5'd5: result = ~(ra ^ rb);
        5'd6: result = ~ra;
        5'd7: result = ra << sh;
        5'd8: result = ra >> sh;
        5'd9: result = 32'($signed(ra) >>> sh);
        default: valid_op = 1'b0;
      endcase
    end else if (fmt == FmtRrr && op == OpSet) begin
      valid_op = fn < 5'd10;
      result   = {31'd0, cmp_cond(fn[3:0], ra, rb)};
    end else if (fmt == FmtRri) begin
      unique case (op)
        4'd0: result = ra + simm;
        4'd1: result = ra + uimm;
        4'd2: result = ra - simm;
        4'd3: result = ra - uimm;
        4'd4: result = ra & uimm;
        4'd5: result = ra | uimm;
        4'd6: result = ra ^ uimm;
        4'd7: result = ~(ra & uimm);
        4'd8: result = ~(ra | uimm);
        4'd9: result = ~(ra ^ uimm);
        4'd10: result = ra << sh;
        4'd11: result = ra >> sh;
        4'd12: result = 32'($signed(ra) >>> sh);
        OpLui: result = {ins[15:0], 16'd0};
        default: valid_op = 1'b0;
      endcase
    end else begin
      valid_op = 1'b0;
    end
  end
endmodule

>>> rtl/risc_decode_execute_core.sv
// Decode/execute core: executes one 32-bit instruction per transfer against
// a 32-entry register file and a MEM_WORDS-word data memory. After reset a
// clearing pass zeroes data memory (stall stays high). Then one instruction
// per cycle is accepted unless the output is stalled: stage 1 registers the
// instruction and the register reads, stage 2 forms the multiply product and
// reads data memory, stage 3 writes back and presents the result. Register
// values are forwarded from later stages, so dependent instructions issue
// back to back; a load followed by a user of its result waits nowhere since
// the loaded word is forwarded straight from the memory read data.
// Depends on rdec_pkg, rdec_alu and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module risc_decode_execute_core #(
  parameter int unsigned MEM_WORDS = rdec_pkg::MemWordsDefault
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  rdec_pkg::in_item_t in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output rdec_pkg::out_item_t out_data
);
  import rdec_pkg::*;
  localparam int unsigned AW = $clog2(MEM_WORDS);

  logic [31:0] rf [32];
  logic [31:0] dmem [MEM_WORDS];

  // Clearing pass over data memory
  logic          clr_busy;
  logic [AW-1:0] clr_addr;
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_busy <= 1'b1;
      clr_addr <= '0;
    end else if (clr_busy) begin
      clr_addr <= clr_addr + 1'b1;
      if (clr_addr == AW'(MEM_WORDS - 1)) clr_busy <= 1'b0;
    end
  end

  // Pipeline: a = decoded/operands, b = executed, then output register
  logic        a_v, b_v;
  logic        advance;
  logic        in_fire;
  assign advance  = !out_valid || !out_stall;
  assign in_stall = clr_busy || !advance;
  assign in_fire  = in_valid && !in_stall;

  // Stage a registers
  logic [31:0] a_ins, a_ra, a_rb, a_r31;
  logic [11:0] a_pc;
  // Stage b registers
  logic [31:0] b_ins, b_ra, b_rb, b_r31, b_prod;
  logic [11:0] b_pc;
  // Writeback bus of stage b (combinational)
  logic        wb_en;
  logic [4:0]  wb_reg;
  logic [31:0] wb_val;
  out_item_t   res;

  // Register read with forwarding from stage b writeback
  function automatic logic [31:0] rd_fwd(input logic [4:0] r, input logic [31:0] v,
                                         input logic en, input logic [4:0] wr,
                                         input logic [31:0] wv);
    if (r == 5'd0) rd_fwd = '0;
    else if (en && wr == r) rd_fwd = wv;
    else rd_fwd = v;
  endfunction

  // Stage a reads see stage b's writeback only; stage a itself updates
  // later, so it is forwarded into stage b below.
  logic [31:0] ra_f, rb_f, r31_f;
  logic        alu_ok;
  logic [31:0] alu_res;
  rdec_alu u_alu (
    .ins(b_ins), .ra(b_ra), .rb(b_rb), .prod(b_prod),
    .valid_op(alu_ok), .result(alu_res)
  );

  always_comb begin
    ra_f  = rd_fwd(a_ins[25:21], a_ra, wb_en && b_v, wb_reg, wb_val);
    rb_f  = rd_fwd(a_ins[20:16], a_rb, wb_en && b_v, wb_reg, wb_val);
    r31_f = rd_fwd(5'd31, a_r31, wb_en && b_v, wb_reg, wb_val);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      a_v <= 1'b0;
      b_v <= 1'b0;
    end else if (advance) begin
      a_v <= in_fire;
      b_v <= a_v;
    end
  end

  // Stage a: read register file, forwarding the current writeback; stage b: operands and product
  always_ff @(posedge clk) begin
    if (advance) begin
      a_ins <= in_data.instruction;
      a_pc  <= in_data.inst_address;
      a_ra  <= rd_fwd(in_data.instruction[25:21], rf[in_data.instruction[25:21]],
                      wb_en && b_v, wb_reg, wb_val);
      a_rb  <= rd_fwd(in_data.instruction[20:16], rf[in_data.instruction[20:16]],
                      wb_en && b_v, wb_reg, wb_val);
      a_r31 <= rd_fwd(5'd31, rf[31], wb_en && b_v, wb_reg, wb_val);
      b_ins  <= a_ins;
      b_pc   <= a_pc;
      b_ra   <= ra_f;
      b_rb   <= rb_f;
      b_r31  <= r31_f;
      b_prod <= ra_f * rb_f;
    end
  end

  // Data memory: read in stage a to b, write from stage b, clear from the clearing pass
  logic [31:0] ld_data;
  logic        st_en;
  logic        ld_fwd;
  logic [31:0] ld_fwd_val;
  always_ff @(posedge clk) begin
    if (clr_busy) dmem[clr_addr] <= '0;
    else if (st_en && advance) dmem[b_ra[AW-1:0]] <= b_rb;
    if (advance) ld_data <= dmem[ra_f[AW-1:0]];
  end
  // A store in b and a load in a to the same word: forward stored data
  always_ff @(posedge clk) begin
    if (advance) begin
      ld_fwd     <= st_en && b_v && b_ra[AW-1:0] == ra_f[AW-1:0];
      ld_fwd_val <= b_rb;
    end
  end

  // Stage b: execute
  always_comb begin
    logic [1:0]  fmt;
    logic [3:0]  op;
    logic [4:0]  fn;
    logic [31:0] simm, jt, lnk;
    logic        take, we, rdr, flt;
    logic [4:0]  rd;
    logic [31:0] wv, tg;
    fmt  = b_ins[31:30];
    op   = b_ins[29:26];
    fn   = b_ins[10:6];
    simm = {{16{b_ins[15]}}, b_ins[15:0]};
    lnk  = {20'd0, b_pc} + 32'd2;
    take = 1'b0; we = 1'b0; rdr = 1'b0; flt = 1'b0;
    rd = '0; wv = '0; tg = '0; st_en = 1'b0;
    jt = '0;
    unique case (fmt)
      FmtRrr: begin
        rd = b_ins[15:11];
        if (op == OpMem) begin
          if (fn == FnLdw || fn == FnStw) begin
            if (b_ra >= MEM_WORDS) flt = 1'b1;
            else if (fn == FnLdw) begin
              we = 1'b1;
              wv = ld_fwd ? ld_fwd_val : ld_data;
            end else st_en = b_v;
          end
        end else if (op == OpJmpl) begin
          if (b_ra >= MEM_WORDS) flt = 1'b1;
          else begin
            we = 1'b1; wv = lnk; rdr = 1'b1; tg = b_ra;
          end
        end else if (op == OpRet) begin
          if (b_r31 >= MEM_WORDS) flt = 1'b1;
          else begin
            rdr = 1'b1; tg = b_r31;
          end
        end else begin
          we = alu_ok; wv = alu_res;
        end
      end
      FmtRri: begin
        rd = b_ins[20:16];
        if (op == OpJmp) take = 1'b1;
        else begin
          we = alu_ok; wv = alu_res;
        end
      end
      FmtBrc: begin
        if (op == 4'd10) take = b_ra == 32'd1;
        else if (op == 4'd11) take = b_ra == 32'd0;
        else take = cmp_cond(op, b_ra, b_rb);
      end
      default: begin
        jt = {2'b00, b_ins[29:0]};
        if (jt >= MEM_WORDS) flt = 1'b1;
        else begin
          rd = 5'd31; we = 1'b1; wv = lnk; rdr = 1'b1; tg = jt;
        end
      end
    endcase
    if (take) begin
      jt = {20'd0, b_pc} + simm;
      if (jt >= MEM_WORDS) flt = 1'b1;
      else begin
        rdr = 1'b1; tg = jt;
      end
    end
    if (!(we && rd != 5'd0)) begin
      we = 1'b0; rd = '0; wv = '0;
    end
    if (!rdr) tg = '0;
    wb_en  = we;
    wb_reg = rd;
    wb_val = wv;
    res.write_enable = we;
    res.write_reg    = rd;
    res.write_value  = wv;
    res.redirect     = rdr;
    res.target       = tg[11:0];
    res.fault        = flt;
  end

  // Writeback and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 32; i++) rf[i] <= '0;
    end else if (advance && b_v && wb_en) begin
      rf[wb_reg] <= wb_val;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else if (advance) out_valid <= b_v;
  end
  always_ff @(posedge clk) begin
    if (advance) out_data <= res;
  end

  // Write to register zero seen on the output
  logic r0_wr;
  assign r0_wr = out_data.write_enable && out_data.write_reg == 5'd0;

  `ASSERT_IMPLIES(a_no_accept_clr, clk, rst, clr_busy, in_stall)
  `ASSERT_IMPLIES(a_no_r0_write, clk, rst, out_valid, !r0_wr)
  `ASSERT_IMPLIES(a_fault_no_redirect, clk, rst, out_valid && out_data.fault, !out_data.redirect)
  `ASSERT_NEXT(a_hold_on_stall, clk, rst, out_valid && out_stall, out_valid && $stable(out_data))
endmodule

>>> dv/testbench.sv
// Self-checking testbench for risc_decode_execute_core: drives instruction
// transfers, predicts each result with a local execute model, compares fields.
// Depends on rdec_pkg and the core RTL.
`timescale 1ns / 1ps
module testbench;
  import rdec_pkg::*;

  localparam int MemWords = 4096;
  localparam int IdleLimit = 20000;  // covers the clearing pass after reset

  logic clk;
  logic rst;
  logic in_valid;
  logic in_stall;
  in_item_t in_data;
  logic out_valid;
  logic out_stall;
  out_item_t out_data;

  risc_decode_execute_core dut (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_stall(in_stall),
    .in_data(in_data), .out_valid(out_valid), .out_stall(out_stall),
    .out_data(out_data)
  );

  // Predicted architectural state
  logic [31:0] gpr [32];
  logic [31:0] dmem [MemWords];
  out_item_t exec_results_q [$];
  int error_count;
  int result_count;
  int idle_cycles;
  bit hold_off;        // long receiver stall request
  int rx_wait = 0;     // receiver wait cycles left for the current transfer
  int rx_draw;

  always begin
    clk = 1'b1;
    #4;
    clk = 1'b0;
    #4;
  end

  // Signed less-than on raw words
  function automatic bit slt(input logic [31:0] a, input logic [31:0] b);
    return $signed(a) < $signed(b);
  endfunction

  function automatic bit compare_cond(input logic [3:0] c, input logic [31:0] a,
                                      input logic [31:0] b);
    case (c)
      4'd0: return a == b;
      4'd1: return a != b;
      4'd2: return slt(a, b);
      4'd3: return a < b;
      4'd4: return !slt(b, a);
      4'd5: return a <= b;
      4'd6: return slt(b, a);
      4'd7: return a > b;
      4'd8: return !slt(a, b);
      4'd9: return a >= b;
      default: return 1'b0;
    endcase
  endfunction

  // Execute one instruction on the predicted state
  function automatic out_item_t execute(input in_item_t it);
    out_item_t r;
    logic [31:0] ins, ra, rb, uimm, simm, wv, jt, pc;
    logic [1:0] fmt;
    logic [3:0] op;
    logic [4:0] fn, rd;
    logic [11:0] tg;
    bit we, rdr, flt, take;
    ins = it.instruction;
    pc = {20'd0, it.inst_address};
    fmt = ins[31:30];
    op = ins[29:26];
    fn = ins[10:6];
    ra = gpr[ins[25:21]];
    rb = gpr[ins[20:16]];
    uimm = {16'd0, ins[15:0]};
    simm = {{16{ins[15]}}, ins[15:0]};
    rd = 5'd0;
    wv = 32'd0;
    tg = 12'd0;
    we = 0;
    rdr = 0;
    flt = 0;
    take = 0;
    if (fmt == FmtRrr) begin
      rd = ins[15:11];
      if (op == OpArith) begin
        we = 1;
        case (fn)
          5'd0, 5'd1: wv = ra + rb;
          5'd2, 5'd3: wv = ra - rb;
          5'd4, 5'd5: wv = ra * rb;
          default: we = 0;
        endcase
      end else if (op == OpLogic) begin
        we = 1;
        case (fn)
          5'd0: wv = ra & rb;
          5'd1: wv = ra | rb;
          5'd2: wv = ra ^ rb;
          5'd3: wv = ~(ra & rb);
          5'd4: wv = ~(ra | rb);
          5'd5: wv = ~(ra ^ rb);
          5'd6: wv = ~ra;
          5'd7: wv = ra << rb[4:0];
          5'd8: wv = ra >> rb[4:0];
          5'd9: wv = $signed(ra) >>> rb[4:0];
          default: we = 0;
        endcase
      end else if (op == OpSet) begin
        if (fn <= 5'd9) begin
          we = 1;
          wv = {31'd0, compare_cond(fn[3:0], ra, rb)};
        end
      end else if (op == OpMem) begin
        if (fn == FnLdw || fn == FnStw) begin
          if (ra >= MemWords) flt = 1;
          else if (fn == FnLdw) begin
            we = 1;
            wv = dmem[ra];
          end else dmem[ra] = rb;
        end
      end else if (op == OpJmpl) begin
        if (ra >= MemWords) flt = 1;
        else begin
          we = 1;
          wv = pc + 2;
          rdr = 1;
          tg = ra[11:0];
        end
      end else if (op == OpRet) begin
        if (gpr[31] >= MemWords) flt = 1;
        else begin
          rdr = 1;
          tg = gpr[31][11:0];
        end
      end
    end else if (fmt == FmtRri) begin
      rd = ins[20:16];
      we = 1;
      case (op)
        4'd0: wv = ra + simm;
        4'd1: wv = ra + uimm;
        4'd2: wv = ra - simm;
        4'd3: wv = ra - uimm;
        4'd4: wv = ra & uimm;
        4'd5: wv = ra | uimm;
        4'd6: wv = ra ^ uimm;
        4'd7: wv = ~(ra & uimm);
        4'd8: wv = ~(ra | uimm);
        4'd9: wv = ~(ra ^ uimm);
        4'd10: wv = ra << uimm[4:0];
        4'd11: wv = ra >> uimm[4:0];
        4'd12: wv = $signed(ra) >>> uimm[4:0];
        OpLui: wv = uimm << 16;
        OpJmp: begin
          we = 0;
          take = 1;
        end
        default: we = 0;
      endcase
    end else if (fmt == FmtBrc) begin
      if (op <= 4'd9) take = compare_cond(op, ra, rb);
      else if (op == 4'd10) take = ra == 32'd1;
      else if (op == 4'd11) take = ra == 32'd0;
    end else begin
      jt = {2'b00, ins[29:0]};
      if (jt >= MemWords) flt = 1;
      else begin
        rd = 5'd31;
        we = 1;
        wv = pc + 2;
        rdr = 1;
        tg = jt[11:0];
      end
    end
    if (take) begin
      jt = pc + simm;
      if (jt >= MemWords) flt = 1;
      else begin
        rdr = 1;
        tg = jt[11:0];
      end
    end
    if (we && rd != 5'd0) gpr[rd] = wv;
    else begin
      we = 0;
      rd = 5'd0;
      wv = 32'd0;
    end
    r.write_enable = we;
    r.write_reg = rd;
    r.write_value = wv;
    r.redirect = rdr;
    r.target = rdr ? tg : 12'd0;
    r.fault = flt;
    return r;
  endfunction

  // Send one instruction transfer after a random gap
  task automatic send_instruction(input logic [31:0] ins, input logic [11:0] pc);
    int gap;
    gap = $urandom_range(0, 10);
    if ($urandom_range(0, 3) == 0) gap = 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= '{instruction: ins, inst_address: pc};
    @(posedge clk);
    while (in_stall) @(posedge clk);
    exec_results_q.push_back(execute('{instruction: ins, inst_address: pc}));
  endtask

  // Instruction builders
  function automatic logic [31:0] rrr(input logic [3:0] op, input int ra,
                                      input int rb, input int rd, input int fn);
    return {FmtRrr, op, ra[4:0], rb[4:0], rd[4:0], fn[4:0], 6'd0};
  endfunction

  function automatic logic [31:0] rri(input logic [3:0] op, input int ra,
                                      input int rd, input logic [15:0] imm);
    return {FmtRri, op, ra[4:0], rd[4:0], imm};
  endfunction

  function automatic logic [31:0] brc(input logic [3:0] op, input int ra,
                                      input int rb, input logic [15:0] imm);
    return {FmtBrc, op, ra[4:0], rb[4:0], imm};
  endfunction

  // Register-sourced values biased toward edges and valid addresses
  task automatic load_constant(input int rd, input logic [31:0] v);
    send_instruction(rri(OpLui, 0, rd, v[31:16]), 12'($urandom));
    send_instruction(rri(4'd5, rd, rd, v[15:0]), 12'($urandom));
  endtask

  function automatic logic [31:0] pick_value();
    case ($urandom_range(0, 5))
      0: return 32'h8000_0000;
      1: return 32'hFFFF_FFFF;
      2: return 32'($urandom_range(0, MemWords - 1));
      3: return 32'($urandom_range(0, 40));
      default: return $urandom;
    endcase
  endfunction

  task automatic test_directed();
    int f;
    load_constant(1, 32'h8000_0000);
    load_constant(2, 32'h7FFF_FFFF);
    load_constant(3, 32'd100);
    send_instruction(rri(4'd0, 0, 0, 16'h1234), 12'd0);       // rd zero
    send_instruction(rrr(OpArith, 1, 2, 4, 4), 12'hFFF);
    send_instruction(rrr(OpLogic, 1, 3, 5, 9), 12'd1);        // ASR
    send_instruction(rrr(OpSet, 1, 2, 6, 3), 12'd2);
    send_instruction(rrr(OpMem, 3, 2, 0, FnStw), 12'd3);
    send_instruction(rrr(OpMem, 3, 0, 7, FnLdw), 12'd4);
    send_instruction(rrr(OpMem, 1, 0, 7, FnLdw), 12'd5);      // fault
    send_instruction(rrr(OpJmpl, 3, 0, 8, 0), 12'hFFF);
    send_instruction({FmtCall, 30'd4095}, 12'hFFE);
    send_instruction(rrr(OpRet, 0, 0, 0, 0), 12'd6);
    send_instruction({FmtCall, 30'h3FFF_FFFF}, 12'd7);        // fault
    send_instruction(brc(4'd3, 3, 1, 16'h8000), 12'hFFF);     // BLTU, out of range
    send_instruction(brc(4'd11, 0, 0, 16'h7FFF), 12'd0);
    send_instruction(rri(OpJmp, 0, 0, 16'hFFFF), 12'd0);      // fault below zero
    send_instruction(32'hFFFF_FFFF, 12'd9);
    for (f = 10; f < 16; f++) send_instruction(rrr(OpLogic, 1, 2, 9, f), 12'd0);
  endtask

  task automatic test_random(input int count);
    int i, kind;
    logic [31:0] ins;
    for (i = 0; i < count; i++) begin
      kind = $urandom_range(0, 9);
      case (kind)
        0: load_constant($urandom_range(1, 31), pick_value());
        1: ins = rrr(OpArith, $urandom, $urandom, $urandom, $urandom_range(0, 6));
        2: ins = rrr(OpLogic, $urandom, $urandom, $urandom, $urandom_range(0, 10));
        3: ins = rrr(OpSet, $urandom, $urandom, $urandom, $urandom_range(0, 10));
        4: ins = rrr(OpMem, $urandom, $urandom, $urandom, $urandom_range(0, 1) * 4);
        5: ins = rri(4'($urandom), $urandom, $urandom, 16'($urandom));
        6: ins = brc(4'($urandom_range(0, 12)), $urandom, $urandom,
                     16'($urandom_range(0, 64) - 32));
        7: ins = {FmtCall, ($urandom_range(0, 3) == 0) ? 30'($urandom)
                                                      : 30'($urandom_range(0, 4095))};
        8: ins = rrr(($urandom_range(0, 1) != 0) ? OpJmpl : OpRet, $urandom,
                     $urandom, $urandom, 0);
        default: ins = $urandom;
      endcase
      if (kind != 0) send_instruction(ins, 12'($urandom));
    end
  endtask

  // Receiver holds off while the sender keeps pushing, filling the pipe
  task automatic test_backpressure();
    hold_off = 1'b1;
    fork
      test_random(30);
      begin
        repeat (60) @(posedge clk);
        hold_off = 1'b0;
      end
    join
  endtask

  // Receiver stall generator: a fresh random wait after each transfer
  always @(posedge clk) begin
    if (rst || hold_off) begin
      out_stall <= 1'b1;
      rx_wait <= 0;
    end else if (out_valid && !out_stall) begin
      rx_draw = $urandom_range(0, 10);
      rx_wait <= rx_draw;
      out_stall <= (rx_draw != 0);
    end else if (rx_wait > 0) begin
      rx_wait <= rx_wait - 1;
      out_stall <= (rx_wait > 1);
    end else begin
      out_stall <= 1'b0;
    end
  end

  // Result checker and idle watchdog
  always @(posedge clk) begin
    if (!rst) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles > IdleLimit) begin
        $display("testbench: done, errors");
        $finish;
      end
      if (out_valid && !out_stall) begin
        if (exec_results_q.size() == 0) begin
          $error("result transfer with nothing expected");
          error_count <= error_count + 1;
        end else begin
          out_item_t e;
          e = exec_results_q.pop_front();
          result_count <= result_count + 1;
          if (out_data !== e) begin
            error_count <= error_count + 1;
            if (out_data.write_enable !== e.write_enable)
              $error("write_enable exp %0d got %0d", e.write_enable, out_data.write_enable);
            if (out_data.write_reg !== e.write_reg)
              $error("write_reg exp %0d got %0d", e.write_reg, out_data.write_reg);
            if (out_data.write_value !== e.write_value)
              $error("write_value exp %h got %h", e.write_value, out_data.write_value);
            if (out_data.redirect !== e.redirect)
              $error("redirect exp %0d got %0d", e.redirect, out_data.redirect);
            if (out_data.target !== e.target)
              $error("target exp %h got %h", e.target, out_data.target);
            if (out_data.fault !== e.fault)
              $error("fault exp %0d got %0d", e.fault, out_data.fault);
          end
        end
      end
    end
  end

  initial begin
    int i;
    for (i = 0; i < 32; i++) gpr[i] = 32'd0;
    for (i = 0; i < MemWords; i++) dmem[i] = 32'd0;
    error_count = 0;
    result_count = 0;
    idle_cycles = 0;
    hold_off = 1'b0;
    rst <= 1'b1;
    in_valid <= 1'b0;
    in_data <= '0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    test_directed();
    test_backpressure();
    test_random(380);
    in_valid <= 1'b0;
    while (exec_results_q.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    $display("Ran directed edge cases, a long receiver hold-off and random programs;");
    $display("%0d results checked, %0d mismatches.", result_count, error_count);
    if (error_count == 0 && exec_results_q.size() == 0) $display("testbench: done, clean");
    else $display("testbench: done, errors");
    $finish;
  end
endmodule
